[hw/rtl/mgd_pkg.sv]
// ----------------------------------------------------------------------------
// mgd_pkg
// Shared constants for the multichannel gate divider: field widths, setup
// register layout, reset values and parameter defaults.
// ----------------------------------------------------------------------------
package mgd_pkg;

    // Parameter defaults
    localparam int CHANNELS_DEF         = 8;
    localparam int TICKS_PER_CYCLE_DEF  = 64;
    localparam int DIVISOR_MAX_DEF      = 16;
    localparam int CLOCK_HIGH_TICKS_DEF = 31;

    // Payload widths
    localparam int TICK_W = 6;
    localparam int GATE_W = 8;

    // Setup registers
    localparam int SETUP_REGS  = 8;
    localparam int SETUP_W     = 16;
    localparam logic [SETUP_W-1:0] SETUP_RESET = 16'h8000;
    localparam int DIV_LSB     = 0;
    localparam int DIV_FLD_W   = 4;
    localparam int PHASE_LSB   = 4;
    localparam int WIDTH_LSB   = 10;
    localparam int FLD_W       = 6;
    localparam int DIV_FIELD_MAX = 16;

    // APB port
    localparam int APB_AW = $clog2(SETUP_REGS) + 2;
    localparam int APB_DW = 32;

endpackage : mgd_pkg

[hw/rtl/mgd_ram.sv]
// ----------------------------------------------------------------------------
// mgd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module mgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule : mgd_ram

[hw/rtl/multichannel_gate_divider.sv]
// ----------------------------------------------------------------------------
// multichannel_gate_divider
// Per-channel gate generator driven by a master tick phase, with divisor,
// phase and width per channel and a master clock output.
// ----------------------------------------------------------------------------
// The block takes one tick beat per clock unless stalled and returns one
// result beat for each. A beat passes the first stage, where the channel
// counters, which all sit in a single RAM row, are read, and then the output
// register. The counter row is read every cycle and written back once per
// beat; the value just written is forwarded to the next beat, so ticks flow
// back to back at one per clock while the output is not stalled. A valid flag
// stands in for the counter reset, so no clearing pass runs after reset. Setup
// registers take effect on the beat accepted in the cycle after the write.
module multichannel_gate_divider
    import mgd_pkg::*;
#(
    parameter int CHANNELS         = mgd_pkg::CHANNELS_DEF,
    parameter int TICKS_PER_CYCLE  = mgd_pkg::TICKS_PER_CYCLE_DEF,
    parameter int DIVISOR_MAX      = mgd_pkg::DIVISOR_MAX_DEF,
    parameter int CLOCK_HIGH_TICKS = mgd_pkg::CLOCK_HIGH_TICKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // tick channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [mgd_pkg::TICK_W-1:0]  i_tick_phase,
    input  logic                        i_resync,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mgd_pkg::GATE_W-1:0]  o_gate_bits,
    output logic                        o_master_clock,
    // APB configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mgd_pkg::APB_AW-1:0]  paddr,
    input  logic [mgd_pkg::APB_DW-1:0]  pwdata,
    output logic [mgd_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    import mgd_pkg::*;

    localparam int EFF_D    = (DIVISOR_MAX < DIV_FIELD_MAX) ? DIVISOR_MAX : DIV_FIELD_MAX;
    localparam int DW       = $clog2(EFF_D + 1);
    localparam int PER_MAX  = TICKS_PER_CYCLE * EFF_D;
    localparam int FLD_MAX  = ((2 ** FLD_W) - 1) * EFF_D;
    localparam int CNT_MAX  = (PER_MAX - 1 > FLD_MAX) ? PER_MAX - 1 : FLD_MAX;
    localparam int CNT_W    = $clog2(CNT_MAX + 1);
    localparam int PER_W    = $clog2(PER_MAX + 1);
    localparam int FW       = $clog2(FLD_MAX + 1);
    localparam int VW0      = (CNT_W > PER_W) ? CNT_W : PER_W;
    localparam int VW       = (VW0 > FW) ? VW0 : FW;
    localparam int SW       = VW + 2;
    localparam int MEM_W    = CHANNELS * CNT_W;
    localparam int RAM_DEPTH = 1;
    localparam int RAM_AW   = 1;
    localparam int IDX_W    = $clog2(SETUP_REGS);

    // ------------------------------------------------------------------
    // Setup registers
    // ------------------------------------------------------------------
    logic [SETUP_W-1:0] r_setup [SETUP_REGS];
    logic               cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = APB_DW'(r_setup[paddr[IDX_W+1:2]]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SETUP_REGS; k++) begin
                r_setup[k] <= SETUP_RESET;
            end
        end else if (cfg_wr) begin
            r_setup[paddr[IDX_W+1:2]] <= pwdata[SETUP_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake and stage control
    // ------------------------------------------------------------------
    logic                r_s1_vld;
    logic [TICK_W-1:0]   r_s1_tick;
    logic                r_s1_resync;
    logic                r_out_vld;
    logic [GATE_W-1:0]   r_gate;
    logic                r_clk_lvl;
    logic                in_acc;
    logic                s1_adv;
    logic                n_clk_lvl;

    assign s1_adv     = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_s1_vld && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_clk_lvl <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
                r_clk_lvl <= n_clk_lvl;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_tick   <= i_tick_phase;
            r_s1_resync <= i_resync;
        end
    end

    always_comb begin
        if (r_s1_tick == '0) begin
            n_clk_lvl = 1'b1;
        end else if (r_s1_tick >= TICK_W'(CLOCK_HIGH_TICKS)) begin
            n_clk_lvl = 1'b0;
        end else begin
            n_clk_lvl = r_clk_lvl;
        end
    end

    // ------------------------------------------------------------------
    // Counter row: registered read every cycle, write back per beat
    // ------------------------------------------------------------------
    logic [MEM_W-1:0] mem_q;
    logic [MEM_W-1:0] wr_word;
    logic [MEM_W-1:0] cur_word;
    logic [MEM_W-1:0] r_fwd;
    logic             r_wr_last;
    logic             r_mem_init;

    mgd_ram #(
        .WIDTH (MEM_W),
        .DEPTH (RAM_DEPTH)
    ) u_cnt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (RAM_AW'(0)),
        .i_wr_data (wr_word),
        .i_rd_en   (1'b1),
        .i_rd_addr (RAM_AW'(0)),
        .o_rd_data (mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_last  <= 1'b0;
            r_mem_init <= 1'b0;
        end else begin
            r_wr_last <= s1_adv;
            if (s1_adv) begin
                r_mem_init <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_fwd <= wr_word;
        end
    end

    // read returns old data when the row was written at the same edge
    always_comb begin
        if (r_wr_last) begin
            cur_word = r_fwd;
        end else if (r_mem_init) begin
            cur_word = mem_q;
        end else begin
            cur_word = '0;
        end
    end

    // ------------------------------------------------------------------
    // Channel lanes
    // ------------------------------------------------------------------
    logic [CHANNELS-1:0] gate_vec;

    for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
        logic [SETUP_W-1:0]      setup;
        logic [DIV_FLD_W:0]      div_raw;
        logic [DW-1:0]           div;
        logic [FLD_W-1:0]        wb;
        logic [FLD_W+DW-1:0]     ph_full;
        logic [FLD_W+DW-1:0]     w_full;
        logic [TICK_W+DW-1:0]    load_full;
        logic [FW-1:0]           r_ph;
        logic [FW-1:0]           r_w;
        logic [PER_W-1:0]        r_per;
        logic [CNT_W-1:0]        r_load;
        logic [CNT_W-1:0]        cnt_in;
        logic signed [SW-1:0]    pos_raw;
        logic signed [SW-1:0]    pos;
        logic [VW:0]             cnt_inc;

        if (i < SETUP_REGS) begin : g_reg
            assign setup = r_setup[i];
        end else begin : g_fixed
            assign setup = SETUP_RESET;
        end

        assign div_raw = {1'b0, setup[DIV_LSB +: DIV_FLD_W]} + (DIV_FLD_W+1)'(1);
        assign div     = (div_raw > (DIV_FLD_W+1)'(EFF_D)) ? DW'(EFF_D) : DW'(div_raw);
        // zero width saturates to one
        assign wb      = (setup[WIDTH_LSB +: FLD_W] == '0) ? FLD_W'(1)
                                                             : setup[WIDTH_LSB +: FLD_W];
        assign ph_full   = (FLD_W+DW)'(setup[PHASE_LSB +: FLD_W]) * (FLD_W+DW)'(div);
        assign w_full    = (FLD_W+DW)'(wb) * (FLD_W+DW)'(div);
        assign load_full = (TICK_W+DW)'(i_tick_phase) * (TICK_W+DW)'(div);

        always_ff @(posedge i_clk) begin
            r_ph  <= FW'(ph_full);
            r_w   <= FW'(w_full);
            r_per <= PER_W'(TICKS_PER_CYCLE * int'(div));
            if (in_acc) begin
                r_load <= CNT_W'(load_full);
            end
        end

        assign cnt_in  = r_s1_resync ? r_load : cur_word[i*CNT_W +: CNT_W];
        assign pos_raw = $signed(SW'(cnt_in)) - $signed(SW'(r_ph));
        // wrap once by the period; a still-negative position reads as inside
        assign pos     = pos_raw[SW-1] ? pos_raw + $signed(SW'(r_per)) : pos_raw;
        assign gate_vec[i] = pos < $signed(SW'(r_w));

        assign cnt_inc = (VW+1)'(cnt_in) + (VW+1)'(1);
        assign wr_word[i*CNT_W +: CNT_W] = (cnt_inc >= (VW+1)'(r_per)) ? '0
                                                                      : CNT_W'(cnt_inc);
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_gate <= GATE_W'(gate_vec);
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_gate_bits    = r_gate;
    assign o_master_clock = r_clk_lvl;

endmodule : multichannel_gate_divider

[hw/rtl/mgd_checker.sv]
// ----------------------------------------------------------------------------
// mgd_checker
// Port-level checks for the multichannel gate divider: output hold under
// stall, reset, tick-side stall, latency and master clock behavior.
// ----------------------------------------------------------------------------
module mgd_checker
    import mgd_pkg::*;
(
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic [mgd_pkg::TICK_W-1:0]  i_tick_phase,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [mgd_pkg::GATE_W-1:0]  o_gate_bits,
    input logic                        o_master_clock
);

    import mgd_pkg::*;

    logic in_beat;
    assign in_beat = i_in_valid && !o_in_stall;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_gate_bits)
                                      && $stable(o_master_clock))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // an empty output stage never backs up the tick side
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("tick side stalled with empty output");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat ##1 !i_out_stall |=> o_out_valid)
        else $error("result beat missing two cycles after tick");

    a_clock_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_tick_phase == '0) ##1 !i_out_stall |=> o_master_clock)
        else $error("master clock low after tick zero");

endmodule : mgd_checker

bind multichannel_gate_divider mgd_checker u_mgd_checker (.*);
